// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the scan core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/wbps_pkg.sv =====
package wbps_pkg;

   // Signature storage limits
   localparam int PATTERN_MAX = 32;
   localparam int CFG_LIMIT   = 32;
   localparam int LEN_LIMIT   = (PATTERN_MAX < CFG_LIMIT) ? PATTERN_MAX : CFG_LIMIT;
   localparam int WIN         = LEN_LIMIT;
   localparam int HIST_DEPTH  = (WIN > 1) ? WIN - 1 : 1;
   localparam int PAT_WORDS   = CFG_LIMIT / 8;
   localparam int POS_W       = $clog2(CFG_LIMIT);
   localparam int LEN_W       = 6;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 32;
   localparam int ADDR_W  = 64;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT0 = 3'd0,
      CSR_PAT1 = 3'd1,
      CSR_PAT2 = 3'd2,
      CSR_PAT3 = 3'd3,
      CSR_MASK = 3'd4,
      CSR_LEN  = 3'd5,
      CSR_BASE = 3'd6
   } csr_idx_type;

   // Signature aligned to the window: slot 0 is the newest byte
   typedef struct packed {
      logic [WIN-1:0][BYTE_W-1:0] exp_bytes;
      logic [WIN-1:0]             care;
      logic                       len_ok;
      logic [LEN_W-1:0]           len;
   } align_type;

endpackage

// ===== rtl/wbps_cfg.sv =====
module wbps_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wbps_pkg::CSR_W-1:0]          csr_wdata,
   output wbps_pkg::align_type                 align,
   output logic [wbps_pkg::ADDR_W-1:0]         region_base
);

   logic [wbps_pkg::PAT_WORDS-1:0][63:0] pat_ff, pat_in;
   logic [wbps_pkg::CFG_LIMIT-1:0]       mask_ff, mask_in;
   logic [wbps_pkg::LEN_W-1:0]           len_ff, len_in;
   logic [wbps_pkg::ADDR_W-1:0]          base_ff, base_in;
   wbps_pkg::align_type                  align_ff, align_in;

   logic [wbps_pkg::CFG_LIMIT-1:0][wbps_pkg::BYTE_W-1:0] sig_bytes;

   assign sig_bytes = pat_ff;

   // Register writes
   always_comb begin
      pat_in  = pat_ff;
      mask_in = mask_ff;
      len_in  = len_ff;
      base_in = base_ff;
      if (csr_we) begin
         case (wbps_pkg::csr_idx_type'(csr_index))
            wbps_pkg::CSR_PAT0: pat_in[0] = csr_wdata;
            wbps_pkg::CSR_PAT1: pat_in[1] = csr_wdata;
            wbps_pkg::CSR_PAT2: pat_in[2] = csr_wdata;
            wbps_pkg::CSR_PAT3: pat_in[3] = csr_wdata;
            wbps_pkg::CSR_MASK: mask_in = csr_wdata[wbps_pkg::CFG_LIMIT-1:0];
            wbps_pkg::CSR_LEN:  len_in = csr_wdata[wbps_pkg::LEN_W-1:0];
            wbps_pkg::CSR_BASE: base_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Window slot j holds the byte that signature position len-1-j is checked against
   always_comb begin
      logic [wbps_pkg::LEN_W-1:0] idx;
      align_in.len    = len_ff;
      align_in.len_ok = (len_ff != '0) &&
                        (len_ff <= wbps_pkg::LEN_W'(wbps_pkg::LEN_LIMIT));
      for (int j = 0; j < wbps_pkg::WIN; j++) begin
         idx = len_ff - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
         align_in.exp_bytes[j] = sig_bytes[idx[wbps_pkg::POS_W-1:0]];
         align_in.care[j]      = (len_ff > wbps_pkg::LEN_W'(j)) &&
                                 !mask_ff[idx[wbps_pkg::POS_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= '0;
         mask_ff  <= '0;
         len_ff   <= '0;
         base_ff  <= '0;
         align_ff <= '0;
      end else begin
         pat_ff   <= pat_in;
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         base_ff  <= base_in;
         align_ff <= align_in;
      end
   end

   assign align       = align_ff;
   assign region_base = base_ff;

endmodule

// ===== rtl/wbps_window.sv =====
module wbps_window (
   input  logic                          clock,
   input  logic                          shift_en,
   input  logic [wbps_pkg::BYTE_W-1:0]   cur_byte,
   input  wbps_pkg::align_type           align,
   output logic                          window_hit
);

   logic [wbps_pkg::HIST_DEPTH-1:0][wbps_pkg::BYTE_W-1:0] hist_ff, hist_in;
   logic [wbps_pkg::WIN-1:0] slot_eq;

   // Byte history, newest in slot 0
   always_comb begin
      hist_in = hist_ff;
      if (shift_en) begin
         hist_in[0] = cur_byte;
         for (int k = 1; k < wbps_pkg::HIST_DEPTH; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   // Compare every slot at once; wildcard and unused slots pass
   always_comb begin
      slot_eq[0] = (cur_byte == align.exp_bytes[0]);
      for (int j = 1; j < wbps_pkg::WIN; j++) begin
         slot_eq[j] = (hist_ff[j-1] == align.exp_bytes[j]);
      end
   end

   assign window_hit = &(~align.care | slot_eq);

endmodule

// ===== rtl/wildcard_byte_pattern_scan_core.sv =====
// A transaction accepted into the input register moves to the output register and shows on rsp_*.
// Throughput: one byte per cycle unless rsp_tready stalls; a byte enters, is compared
// against the whole signature in one step and lands in the output register.
// Reset (synchronous, active high) clears the configuration registers, the byte count, the found
// flag and both pipeline valid bits; byte history is not cleared.
module wildcard_byte_pattern_scan_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tuser,   // [0] region_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // [63:0] match_address
   output logic                                rsp_tuser,   // [0] match
   input  logic                                csr_we,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wbps_pkg::CSR_W-1:0]          csr_wdata
);

`include "assert_macros.svh"

   wbps_pkg::align_type              align;
   logic [wbps_pkg::ADDR_W-1:0]      region_base;
   logic                             window_hit;

   logic                             s1_valid_ff, s1_valid_in;
   logic [wbps_pkg::BYTE_W-1:0]      s1_data_ff, s1_data_in;
   logic                             s1_start_ff, s1_start_in;
   logic [wbps_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                             found_ff, found_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_match_ff, out_match_in;
   logic [wbps_pkg::ADDR_W-1:0]      out_addr_ff, out_addr_in;

   logic                             advance;
   logic                             req_take;
   logic [wbps_pkg::CNT_W-1:0]       cnt_base, cnt_new, cnt_off;
   logic                             found_base;
   logic                             hit;

   wbps_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .align       (align),
      .region_base (region_base)
   );

   wbps_window u_window (
      .clock      (clock),
      .shift_en   (advance),
      .cur_byte   (s1_data_ff),
      .align      (align),
      .window_hit (window_hit)
   );

   // Handshake: stage 1 moves on when the output register is free or draining
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Input register
   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !advance);
      s1_data_in  = req_take ? req_tdata : s1_data_ff;
      s1_start_in = req_take ? req_tuser : s1_start_ff;
   end

   // Count and found flag as seen by the byte in stage 1
   always_comb begin
      cnt_base   = s1_start_ff ? '0 : count_ff;
      found_base = s1_start_ff ? 1'b0 : found_ff;
      cnt_new    = (cnt_base == wbps_pkg::CNT_MAX) ? cnt_base
                                                   : cnt_base + wbps_pkg::CNT_W'(1);
      hit        = !found_base && align.len_ok && window_hit &&
                   (cnt_new >= wbps_pkg::CNT_W'(align.len));
      cnt_off    = cnt_new - wbps_pkg::CNT_W'(align.len);
   end

   // State update and output register
   always_comb begin
      count_in     = count_ff;
      found_in     = found_ff;
      out_match_in = out_match_ff;
      out_addr_in  = out_addr_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance) begin
         count_in     = cnt_new;
         found_in     = found_base || hit;
         out_valid_in = 1'b1;
         out_match_in = hit;
         out_addr_in  = hit ? region_base + wbps_pkg::ADDR_W'(cnt_off) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      s1_start_ff  <= s1_start_in;
      out_match_ff <= out_match_in;
      out_addr_ff  <= out_addr_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_addr_ff;
   assign rsp_tuser  = out_match_ff;

   // Checks
   `ASSERT_IMPL(a_no_match_zero_addr, clock, reset,
                out_valid_ff && !out_match_ff, out_addr_ff == '0)
   `ASSERT_NEXT(a_single_match, clock, reset,
                advance && found_ff && !s1_start_ff, !out_match_ff)
   `ASSERT_IMPL(a_full_pipe_stalls, clock, reset,
                s1_valid_ff && out_valid_ff && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_count_monotonic, clock, reset,
                advance && !s1_start_ff, count_ff >= $past(count_ff))

endmodule

// ===== bench/wildcard_byte_pattern_scan_core_tb.sv =====
module wildcard_byte_pattern_scan_core_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 100;
   localparam int REPORT_LINES  = 40;

   // Expected result of one scanned byte
   typedef struct packed {
      logic        hit;
      logic [63:0] addr;
   } scan_hit_type;

   // Scan predictor plus expected-result store
   class sig_scan_scoreboard;
      bit [255:0]   sig;
      bit [31:0]    wild;
      bit [5:0]     len;
      bit [63:0]    base;
      bit [7:0]     hist [wbps_pkg::HIST_DEPTH];
      bit [31:0]    seen;
      bit           found;
      scan_hit_type pending_hits[$];
      int           mismatches;

      function void set_reg(wbps_pkg::csr_idx_type idx, bit [63:0] v);
         case (idx)
            wbps_pkg::CSR_PAT0, wbps_pkg::CSR_PAT1,
            wbps_pkg::CSR_PAT2, wbps_pkg::CSR_PAT3: begin
               sig[int'(idx)*64 +: 64] = v;
            end
            wbps_pkg::CSR_MASK: wild = v[31:0];
            wbps_pkg::CSR_LEN:  len  = v[5:0];
            wbps_pkg::CSR_BASE: base = v;
            default: ;
         endcase
      endfunction

      // Full-window compare against the signature, newest byte is cur
      function bit window_hit(bit [7:0] cur);
         int      back;
         bit [7:0] b;
         if (len == 0 || len > wbps_pkg::LEN_LIMIT || seen < 32'(len))
            return 1'b0;
         for (int i = 0; i < len; i++) begin
            if (wild[i])
               continue;
            back = len - 1 - i;
            b = (back == 0) ? cur : hist[back-1];
            if (b != sig[i*8 +: 8])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_byte(bit [7:0] cur, bit start);
         scan_hit_type r;
         bit [31:0] offset;
         if (start) begin
            seen  = '0;
            found = 1'b0;
         end
         if (seen != '1)
            seen++;
         r.hit  = !found && window_hit(cur);
         offset = seen - 32'(len);
         r.addr = r.hit ? base + {32'b0, offset} : '0;
         if (r.hit)
            found = 1'b1;
         pending_hits.push_back(r);
         for (int k = wbps_pkg::HIST_DEPTH-1; k > 0; k--)
            hist[k] = hist[k-1];
         hist[0] = cur;
      endfunction

      task report_mismatch(string msg);
         if (mismatches < REPORT_LINES)
            $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task compare_result(logic hit, logic [63:0] addr);
         scan_hit_type e;
         if (pending_hits.size() == 0) begin
            report_mismatch($sformatf("unexpected result hit=%0b addr=%h", hit, addr));
            return;
         end
         e = pending_hits.pop_front();
         if (hit !== e.hit)
            report_mismatch($sformatf("match got %b exp %b", hit, e.hit));
         if (addr !== e.addr)
            report_mismatch($sformatf("match_address got %h exp %h", addr, e.addr));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tuser = 1'b0;  // [0] region_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [63:0] match_address
   logic        rsp_tuser;         // [0] match
   logic        csr_we = 1'b0;
   logic [wbps_pkg::CSR_IDX_W-1:0] csr_index = wbps_pkg::CSR_PAT0;
   logic [wbps_pkg::CSR_W-1:0]     csr_wdata = '0;

   sig_scan_scoreboard sb = new();

   bit         quiet;
   int         items;
   int         cycle_count;
   int         stall_left;
   bit [255:0] cur_sig;
   bit [31:0]  cur_wild;
   bit [5:0]   cur_len;

   wildcard_byte_pattern_scan_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: check accepted transactions, stall in short bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.compare_result(rsp_tuser, rsp_tdata);
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic put_reg(wbps_pkg::csr_idx_type idx, bit [63:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic load_signature(bit [255:0] s, bit [31:0] m, bit [5:0] l, bit [63:0] b);
      put_reg(wbps_pkg::CSR_PAT0, s[63:0]);
      put_reg(wbps_pkg::CSR_PAT1, s[127:64]);
      put_reg(wbps_pkg::CSR_PAT2, s[191:128]);
      put_reg(wbps_pkg::CSR_PAT3, s[255:192]);
      put_reg(wbps_pkg::CSR_MASK, {32'b0, m});
      put_reg(wbps_pkg::CSR_LEN, {58'b0, l});
      put_reg(wbps_pkg::CSR_BASE, b);
      csr_we   <= 1'b0;
      cur_sig  = s;
      cur_wild = m;
      cur_len  = l;
   endtask

   task automatic send_byte(bit [7:0] d, bit s);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(d, s);
      items++;
   endtask

   // Hold off the sender until every expected result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Noise, then the signature with random bytes at wildcard positions;
   // some copies get a flipped bit or are cut short
   task automatic send_segment(bit start, int plant_len);
      int       noise;
      int       kind;
      int       bad_pos;
      int       stop;
      bit       first;
      bit [7:0] b;
      noise   = $urandom_range(0, 6);
      kind    = $urandom_range(0, 5);
      bad_pos = $urandom_range(0, plant_len - 1);
      stop    = (kind == 1) ? $urandom_range(0, plant_len - 1) : plant_len;
      first   = start;
      for (int n = 0; n < noise; n++) begin
         send_byte(8'($urandom), first);
         first = 1'b0;
      end
      for (int i = 0; i < stop; i++) begin
         b = cur_wild[i] ? 8'($urandom) : cur_sig[i*8 +: 8];
         if (kind == 0 && i == bad_pos)
            b ^= 8'(1 << $urandom_range(0, 7));
         send_byte(b, first);
         first = 1'b0;
      end
   endtask

   initial begin
      bit [255:0] s;
      bit [31:0]  m;
      bit [5:0]   l;
      bit [63:0]  b;
      int         plant_len;
      int         phase_end;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: zero length never matches
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      drain();

      // Four-byte signature with a wildcard; address wraps past 2^64
      load_signature({224'b0, 32'h5AFF_00A5}, 32'h2, 6'd4, 64'hFFFF_FFFF_FFFF_FFFE);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h13, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      // second hit in the same region is suppressed
      send_byte(8'hA5, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      // new region reports again, window at offset zero
      send_byte(8'hA5, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      drain();

      // Length beyond the signature store never matches
      load_signature('1, '1, 6'd63, '1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      drain();

      // Random phases, each with its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         for (int w = 0; w < 8; w++)
            s[w*32 +: 32] = $urandom;
         case ($urandom_range(0, 3))
            0:       m = '0;
            1:       m = '1;
            2:       m = $urandom;
            default: m = $urandom & $urandom & $urandom;
         endcase
         case (ph)
            0:       l = 6'd32;
            1:       l = 6'd1;
            2:       l = 6'd0;
            3:       l = 6'($urandom_range(33, 63));
            4:       l = 6'd32;
            default: l = 6'($urandom_range(2, 31));
         endcase
         case (ph % 3)
            0:       b = '1;
            1:       b = '0;
            default: b = {$urandom, $urandom};
         endcase
         load_signature(s, m, l, b);
         plant_len = (l == 0) ? 1 : (l > wbps_pkg::LEN_LIMIT) ? wbps_pkg::LEN_LIMIT : l;
         // no idling on either side in the last phase
         quiet = (ph == PHASES - 1);
         phase_end = items + PHASE_ITEMS;
         while (items < phase_end)
            send_segment($urandom_range(0, 1), plant_len);
         drain();
      end

      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
